### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bmrf_pkg.sv
// ----------------------------------------------------------------------------
// Banked mode register file package
// Widths, command and index codes, mode codes and shared types.
// ----------------------------------------------------------------------------
package bmrf_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 5;
   localparam int MODE_W = 5;
   localparam int CMD_W  = 2;
   localparam int SUB_W  = 3;
   localparam int GRP_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_INIT  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [IDX_W-1:0] IDX_R0   = 5'd0;
   localparam logic [IDX_W-1:0] IDX_R7   = 5'd7;
   localparam logic [IDX_W-1:0] IDX_R8   = 5'd8;
   localparam logic [IDX_W-1:0] IDX_R12  = 5'd12;
   localparam logic [IDX_W-1:0] IDX_SP   = 5'd13;
   localparam logic [IDX_W-1:0] IDX_LR   = 5'd14;
   localparam logic [IDX_W-1:0] IDX_PC   = 5'd15;
   localparam logic [IDX_W-1:0] IDX_CPSR = 5'd16;
   localparam logic [IDX_W-1:0] IDX_SPSR = 5'd17;
   localparam logic [IDX_W-1:0] IDX_FPS  = 5'd18;

   localparam logic [MODE_W-1:0] USER_MODE = 5'd16;
   localparam logic [MODE_W-1:0] FIQ_MODE  = 5'd17;
   localparam logic [MODE_W-1:0] IRQ_MODE  = 5'd18;
   localparam logic [MODE_W-1:0] SVC_MODE  = 5'd19;
   localparam logic [MODE_W-1:0] ABT_MODE  = 5'd23;
   localparam logic [MODE_W-1:0] UND_MODE  = 5'd27;
   localparam logic [MODE_W-1:0] SYS_MODE  = 5'd31;

   localparam int NUM_LOW    = 8;
   localparam int NUM_HIGH   = 5;
   localparam int NUM_GROUPS = 6;

   localparam logic [GRP_W-1:0] GRP_USR = 3'd0;
   localparam logic [GRP_W-1:0] GRP_SVC = 3'd1;
   localparam logic [GRP_W-1:0] GRP_ABT = 3'd2;
   localparam logic [GRP_W-1:0] GRP_UND = 3'd3;
   localparam logic [GRP_W-1:0] GRP_IRQ = 3'd4;
   localparam logic [GRP_W-1:0] GRP_FIQ = 3'd5;

   localparam logic [DATA_W-1:0] CPSR_RESET     = 32'h4000_01d3;
   localparam logic [DATA_W-1:0] RESET_PC_VALUE = 32'h0000_0000;
   localparam logic [DATA_W-1:0] PC_READ_OFFSET = 32'd4;

   // Storage element that one access touches.
   typedef enum logic [3:0] {
      T_NONE,
      T_LOW,
      T_USR_HIGH,
      T_FIQ_HIGH,
      T_SP,
      T_LR,
      T_SPSR,
      T_PC,
      T_CPSR
   } target_type;

   typedef struct packed {
      target_type        target;
      logic [SUB_W-1:0]  sub;
      logic [GRP_W-1:0]  group;
      logic              is_read;
      logic              is_write;
      logic              is_init;
      logic              err;
   } access_type;

   function automatic logic [DATA_W-1:0] spsr_reset(input logic [GRP_W-1:0] grp);
      logic [DATA_W-1:0] value;
      unique case (grp)
         GRP_USR: value = 32'h4000_01d0;
         GRP_SVC: value = 32'h4000_01d3;
         GRP_ABT: value = 32'h4000_01d7;
         GRP_UND: value = 32'h4000_01db;
         GRP_IRQ: value = 32'h4000_01d2;
         GRP_FIQ: value = 32'h4000_01d1;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

### rtl/bmrf_if.sv
// ----------------------------------------------------------------------------
// Banked mode register file channels
// Request and response interfaces with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmrf_req_if;
   logic                             valid;
   logic                             ready;
   logic [bmrf_pkg::CMD_W-1:0]       command;
   logic [bmrf_pkg::IDX_W-1:0]       reg_index;
   logic [bmrf_pkg::MODE_W-1:0]      mode;
   logic [bmrf_pkg::DATA_W-1:0]      write_data;

   modport source (output valid, command, reg_index, mode, write_data, input ready);
   modport sink   (input valid, command, reg_index, mode, write_data, output ready);
endinterface

interface bmrf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bmrf_pkg::DATA_W-1:0]      read_data;
   logic                             error;

   modport source (output valid, read_data, error, input ready);
   modport sink   (input valid, read_data, error, output ready);
endinterface

### rtl/bmrf_decode.sv
// ----------------------------------------------------------------------------
// Access decoder
// Maps command, register index and mode to a storage target and error flag.
// ----------------------------------------------------------------------------
module bmrf_decode (
   input  logic [bmrf_pkg::CMD_W-1:0]  command,
   input  logic [bmrf_pkg::IDX_W-1:0]  reg_index,
   input  logic [bmrf_pkg::MODE_W-1:0] mode,
   output bmrf_pkg::access_type        access
);

   logic [bmrf_pkg::GRP_W-1:0] group;
   logic                       group_ok;
   logic                       is_read;
   logic                       is_write;

   always_comb begin
      group_ok = 1'b1;
      unique case (mode)
         bmrf_pkg::USER_MODE, bmrf_pkg::SYS_MODE: group = bmrf_pkg::GRP_USR;
         bmrf_pkg::SVC_MODE: group = bmrf_pkg::GRP_SVC;
         bmrf_pkg::ABT_MODE: group = bmrf_pkg::GRP_ABT;
         bmrf_pkg::UND_MODE: group = bmrf_pkg::GRP_UND;
         bmrf_pkg::IRQ_MODE: group = bmrf_pkg::GRP_IRQ;
         bmrf_pkg::FIQ_MODE: group = bmrf_pkg::GRP_FIQ;
         default: begin
            group    = bmrf_pkg::GRP_USR;
            group_ok = 1'b0;
         end
      endcase
   end

   assign is_read  = (bmrf_pkg::cmd_type'(command) == bmrf_pkg::CMD_READ);
   assign is_write = (bmrf_pkg::cmd_type'(command) == bmrf_pkg::CMD_WRITE);

   always_comb begin
      access          = '0;
      access.target   = bmrf_pkg::T_NONE;
      access.group    = group;
      // Registers 0-7 and 8-12 both select their slot by the low three bits.
      access.sub      = reg_index[bmrf_pkg::SUB_W-1:0];
      access.is_read  = is_read;
      access.is_write = is_write;
      access.is_init  = (bmrf_pkg::cmd_type'(command) == bmrf_pkg::CMD_INIT);
      unique case (reg_index) inside
         [bmrf_pkg::IDX_R0:bmrf_pkg::IDX_R7]: access.target = bmrf_pkg::T_LOW;
         [bmrf_pkg::IDX_R8:bmrf_pkg::IDX_R12]: begin
            access.target = (mode == bmrf_pkg::FIQ_MODE) ? bmrf_pkg::T_FIQ_HIGH
                                                         : bmrf_pkg::T_USR_HIGH;
         end
         bmrf_pkg::IDX_SP: begin
            access.target = group_ok ? bmrf_pkg::T_SP : bmrf_pkg::T_NONE;
            access.err    = !group_ok;
         end
         bmrf_pkg::IDX_LR: begin
            access.target = group_ok ? bmrf_pkg::T_LR : bmrf_pkg::T_NONE;
            access.err    = !group_ok;
         end
         bmrf_pkg::IDX_SPSR: begin
            access.target = group_ok ? bmrf_pkg::T_SPSR : bmrf_pkg::T_NONE;
            access.err    = !group_ok;
         end
         bmrf_pkg::IDX_PC:   access.target = bmrf_pkg::T_PC;
         bmrf_pkg::IDX_CPSR: access.target = bmrf_pkg::T_CPSR;
         bmrf_pkg::IDX_FPS:  access.target = bmrf_pkg::T_NONE;
         default:            access.err    = 1'b1;
      endcase
      // Init and the unused command touch no single register and never fail.
      if (!(is_read || is_write)) begin
         access.target = bmrf_pkg::T_NONE;
         access.err    = 1'b0;
      end
   end

endmodule

### rtl/bmrf_regs.sv
// ----------------------------------------------------------------------------
// Register storage
// Shared, banked and special registers with one read and one write per cycle.
// ----------------------------------------------------------------------------
module bmrf_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  bmrf_pkg::access_type        access,
   input  logic [bmrf_pkg::DATA_W-1:0] write_data,
   input  logic [bmrf_pkg::DATA_W-1:0] reset_pc,
   output logic [bmrf_pkg::DATA_W-1:0] read_data
);

   logic [bmrf_pkg::DATA_W-1:0] low_ff  [bmrf_pkg::NUM_LOW];
   logic [bmrf_pkg::DATA_W-1:0] usr_ff  [bmrf_pkg::NUM_HIGH];
   logic [bmrf_pkg::DATA_W-1:0] fiq_ff  [bmrf_pkg::NUM_HIGH];
   logic [bmrf_pkg::DATA_W-1:0] sp_ff   [bmrf_pkg::NUM_GROUPS];
   logic [bmrf_pkg::DATA_W-1:0] lr_ff   [bmrf_pkg::NUM_GROUPS];
   logic [bmrf_pkg::DATA_W-1:0] spsr_ff [bmrf_pkg::NUM_GROUPS];
   logic [bmrf_pkg::DATA_W-1:0] pc_ff;
   logic [bmrf_pkg::DATA_W-1:0] cpsr_ff;
   logic [bmrf_pkg::DATA_W-1:0] pc_in;
   logic                        restore;
   logic                        do_write;
   logic [bmrf_pkg::DATA_W-1:0] value;

   assign restore  = reset || (step && access.is_init);
   assign do_write = step && access.is_write;
   assign pc_in    = reset ? bmrf_pkg::RESET_PC_VALUE : reset_pc;

   always_ff @(posedge clock) begin
      if (restore) begin
         for (int i = 0; i < bmrf_pkg::NUM_LOW; i++) begin
            low_ff[i] <= '0;
         end
         for (int i = 0; i < bmrf_pkg::NUM_HIGH; i++) begin
            usr_ff[i] <= '0;
            fiq_ff[i] <= '0;
         end
         for (int i = 0; i < bmrf_pkg::NUM_GROUPS; i++) begin
            sp_ff[i]   <= '0;
            lr_ff[i]   <= '0;
            spsr_ff[i] <= bmrf_pkg::spsr_reset(bmrf_pkg::GRP_W'(i));
         end
         pc_ff   <= pc_in;
         cpsr_ff <= bmrf_pkg::CPSR_RESET;
      end else if (do_write) begin
         case (access.target)
            bmrf_pkg::T_LOW:      low_ff[access.sub]    <= write_data;
            bmrf_pkg::T_USR_HIGH: usr_ff[access.sub]    <= write_data;
            bmrf_pkg::T_FIQ_HIGH: fiq_ff[access.sub]    <= write_data;
            bmrf_pkg::T_SP:       sp_ff[access.group]   <= write_data;
            bmrf_pkg::T_LR:       lr_ff[access.group]   <= write_data;
            bmrf_pkg::T_SPSR:     spsr_ff[access.group] <= write_data;
            bmrf_pkg::T_PC:       pc_ff                 <= write_data;
            bmrf_pkg::T_CPSR:     cpsr_ff               <= write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (access.target)
         bmrf_pkg::T_LOW:      value = low_ff[access.sub];
         bmrf_pkg::T_USR_HIGH: value = usr_ff[access.sub];
         bmrf_pkg::T_FIQ_HIGH: value = fiq_ff[access.sub];
         bmrf_pkg::T_SP:       value = sp_ff[access.group];
         bmrf_pkg::T_LR:       value = lr_ff[access.group];
         bmrf_pkg::T_SPSR:     value = spsr_ff[access.group];
         bmrf_pkg::T_PC:       value = pc_ff + bmrf_pkg::PC_READ_OFFSET;
         bmrf_pkg::T_CPSR:     value = cpsr_ff;
         default:              value = '0;
      endcase
   end

   assign read_data = access.is_read ? value : '0;

endmodule

### rtl/banked_mode_register_file_top.sv
// ----------------------------------------------------------------------------
// Banked mode register file
// Mode-banked processor register file behind request and response channels.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock and returns exactly one response
// beat per request, in order. A request is captured in an input register; once
// the output register is free or drains, it is decoded, the register storage is
// read and written, and the response is loaded into the output register. A write
// or init is visible to the request that follows it directly. Throughput is one
// beat per cycle and is only reduced by backpressure on the response channel.
// The reset PC register must be written through the CSR port only while no
// request is in flight; the block itself does not enforce this. Init reloads
// the program counter from that register.
module banked_mode_register_file_top (
   input  logic                        clock,
   input  logic                        reset,
   bmrf_req_if.sink                    req_ch,
   bmrf_rsp_if.source                  rsp_ch,
   input  logic                        csr_write_enable,
   input  logic [bmrf_pkg::DATA_W-1:0] csr_write_data
);

   logic                          in_valid_ff;
   logic [bmrf_pkg::CMD_W-1:0]    in_command_ff;
   logic [bmrf_pkg::IDX_W-1:0]    in_index_ff;
   logic [bmrf_pkg::MODE_W-1:0]   in_mode_ff;
   logic [bmrf_pkg::DATA_W-1:0]   in_data_ff;
   logic                          out_valid_ff;
   logic [bmrf_pkg::DATA_W-1:0]   out_data_ff;
   logic                          out_error_ff;
   logic [bmrf_pkg::DATA_W-1:0]   reset_pc_ff;
   logic                          step;
   logic                          accept;
   bmrf_pkg::access_type          access;
   logic [bmrf_pkg::DATA_W-1:0]   read_data;

   // The held request moves on whenever the output register is free or drains.
   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_pc_ff <= bmrf_pkg::RESET_PC_VALUE;
      end else if (csr_write_enable) begin
         reset_pc_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_command_ff <= req_ch.command;
         in_index_ff   <= req_ch.reg_index;
         in_mode_ff    <= req_ch.mode;
         in_data_ff    <= req_ch.write_data;
      end
   end

   bmrf_decode u_decode (
      .command   (in_command_ff),
      .reg_index (in_index_ff),
      .mode      (in_mode_ff),
      .access    (access)
   );

   bmrf_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .access     (access),
      .write_data (in_data_ff),
      .reset_pc   (reset_pc_ff),
      .read_data  (read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff  <= read_data;
         out_error_ff <= access.err;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.read_data = out_data_ff;
   assign rsp_ch.error     = out_error_ff;

endmodule

### rtl/bmrf_checker.sv
// ----------------------------------------------------------------------------
// Banked mode register file checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmrf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bmrf_pkg::DATA_W-1:0] rsp_read_data,
   input logic                        rsp_error
);

   // A failed access never returns register contents.
   `ASSERT_CLK_RST(a_error_zero_data, clock, reset, (rsp_valid && rsp_error) |-> (rsp_read_data == '0), "error beat with nonzero data")

   // With the output register empty, the request side can never be stalled.
   `ASSERT_CLK_RST(a_ready_when_drained, clock, reset, (!rsp_valid) |-> req_ready, "request stalled with empty response side")

   `ASSERT_CLK(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid right after reset")

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data) && $stable(rsp_error)), "stalled response beat changed")

endmodule

bind banked_mode_register_file_top bmrf_checker u_bmrf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_error     (rsp_ch.error)
);
